// ===== src/iot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iot_pkg;

    localparam int FIELD_W = 32;
    localparam logic [6:0] PEAK_MAX = 7'd127;

    typedef struct packed {
        logic [FIELD_W-1:0] left_pos;
        logic [FIELD_W-1:0] right_pos;
        logic               last_interval;
        logic               set_empty;
    } in_item_t;

    typedef struct packed {
        logic       overlap_found;
        logic [6:0] peak_cover;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear;
        logic peak_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/iot_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iot_cell #(
    parameter int COORD_WIDTH = 32,
    parameter int CNT_W       = 7
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire iot_pkg::cell_ctl_t     ctl,
    input  wire logic [COORD_WIDTH-1:0] prev_left,
    input  wire logic [COORD_WIDTH-1:0] prev_right,
    input  wire logic                   prev_valid,
    input  wire logic [CNT_W-1:0]       prev_peak,
    output logic      [COORD_WIDTH-1:0] left_out,
    output logic      [COORD_WIDTH-1:0] right_out,
    output logic                        valid_out,
    output logic      [CNT_W-1:0]       peak_out
);

    // fixed copy of this cell's interval, probed at its left end
    logic [COORD_WIDTH-1:0] probe_left_reg, probe_left_next;
    logic                   probe_valid_reg, probe_valid_next;

    // interval passing along the ring
    logic [COORD_WIDTH-1:0] mv_left_reg, mv_left_next;
    logic [COORD_WIDTH-1:0] mv_right_reg, mv_right_next;
    logic                   mv_valid_reg, mv_valid_next;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       peak_reg, peak_next;
    logic                   hit;
    logic [CNT_W-1:0]       own_cnt;

    assign hit = mv_valid_reg && probe_valid_reg
                 && (mv_left_reg <= probe_left_reg)
                 && (probe_left_reg <= mv_right_reg);

    assign own_cnt = probe_valid_reg ? cnt_reg : '0;

    always_comb
    begin
        probe_left_next  = probe_left_reg;
        probe_valid_next = probe_valid_reg;
        mv_left_next     = mv_left_reg;
        mv_right_next    = mv_right_reg;
        mv_valid_next    = mv_valid_reg;
        cnt_next         = cnt_reg;
        peak_next        = peak_reg;

        if (ctl.shift)
        begin
            probe_left_next  = prev_left;
            probe_valid_next = prev_valid;
        end
        if (ctl.shift || ctl.rotate)
        begin
            mv_left_next  = prev_left;
            mv_right_next = prev_right;
            mv_valid_next = prev_valid;
        end

        if (ctl.rotate && hit)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (ctl.rotate)
        begin
            peak_next = '0;
        end
        else if (ctl.peak_en)
        begin
            peak_next = (own_cnt > prev_peak) ? own_cnt : prev_peak;
        end

        if (ctl.clear)
        begin
            probe_valid_next = 1'b0;
            mv_valid_next    = 1'b0;
            cnt_next         = '0;
            peak_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
            mv_valid_reg    <= 1'b0;
            cnt_reg         <= '0;
            peak_reg        <= '0;
        end
        else
        begin
            probe_valid_reg <= probe_valid_next;
            mv_valid_reg    <= mv_valid_next;
            cnt_reg         <= cnt_next;
            peak_reg        <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_left_reg <= probe_left_next;
        mv_left_reg    <= mv_left_next;
        mv_right_reg   <= mv_right_next;
    end

    assign left_out  = mv_left_reg;
    assign right_out = mv_right_reg;
    assign valid_out = mv_valid_reg;
    assign peak_out  = peak_reg;

endmodule

`default_nettype wire

// ===== src/interval_overlap_threshold_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// in        | in_valid / in_stall       | in_data  (iot_pkg::in_item_t)
// out       | out_valid / out_stall     | out_data (iot_pkg::out_item_t)
// config    | psel penable pwrite pready| paddr pwdata prdata
//
// an interval is taken while in_stall is low and, unless reversed, empty or past
// MAX_INTERVALS, shifts into the cell chain; after a transfer that ends a set the ring
// rotates once for the counts, then the peak walks down the chain
// in_stall is high from the end of a set until its result is in the output register
// the result register holds while out_stall is high; reset empties all cells

module interval_overlap_threshold_core #(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_WIDTH   = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire iot_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output iot_pkg::out_item_t       out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_COUNT = 2'd1;
    localparam logic [1:0] S_PEAK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic REG_COVER_THRESHOLD = 1'b0;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]         stored_reg, stored_next;
    logic [15:0]              thr_reg, thr_next;
    logic                     out_valid_reg, out_valid_next;
    iot_pkg::out_item_t       out_data_reg, out_data_next;

    iot_pkg::cell_ctl_t       ctl;
    logic                     in_xfer;
    logic                     store;
    logic                     set_end;
    logic                     phase_last;
    logic                     out_free;
    logic [63:0]              left_wide;
    logic [63:0]              right_wide;
    logic [COORD_WIDTH-1:0]   new_left;
    logic [COORD_WIDTH-1:0]   new_right;
    logic [EXT_W-1:0]         peak_ext;
    logic [6:0]               peak_sat;

    logic [COORD_WIDTH-1:0]   c_left  [MAX_INTERVALS];
    logic [COORD_WIDTH-1:0]   c_right [MAX_INTERVALS];
    logic                     c_valid [MAX_INTERVALS];
    logic [CNT_W-1:0]         c_peak  [MAX_INTERVALS];

    logic [COORD_WIDTH-1:0]   head_left;
    logic [COORD_WIDTH-1:0]   head_right;
    logic                     head_valid;

    assign left_wide  = {32'b0, in_data.left_pos};
    assign right_wide = {32'b0, in_data.right_pos};
    assign new_left   = left_wide[COORD_WIDTH-1:0];
    assign new_right  = right_wide[COORD_WIDTH-1:0];

    assign in_stall   = (state_reg != S_LOAD);
    assign in_xfer    = in_valid && !in_stall;
    assign store      = in_xfer && !in_data.set_empty && (new_right >= new_left)
                        && (stored_reg != CNT_W'(MAX_INTERVALS));
    assign set_end    = in_xfer && (in_data.last_interval || in_data.set_empty);
    assign phase_last = (phase_reg == CNT_W'(MAX_INTERVALS - 1));
    assign out_free   = !out_valid_reg || !out_stall;

    // head of the ring: new interval while loading, tail of the chain while counting
    assign head_left  = ctl.shift ? new_left  : c_left[MAX_INTERVALS-1];
    assign head_right = ctl.shift ? new_right : c_right[MAX_INTERVALS-1];
    assign head_valid = ctl.shift ? 1'b1      : c_valid[MAX_INTERVALS-1];

    genvar k;
    generate
        for (k = 0; k < MAX_INTERVALS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                iot_cell #(
                    .COORD_WIDTH (COORD_WIDTH),
                    .CNT_W       (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .prev_left  (head_left),
                    .prev_right (head_right),
                    .prev_valid (head_valid),
                    .prev_peak  ({CNT_W{1'b0}}),
                    .left_out   (c_left[k]),
                    .right_out  (c_right[k]),
                    .valid_out  (c_valid[k]),
                    .peak_out   (c_peak[k])
                );
            end
            else
            begin : g_body
                iot_cell #(
                    .COORD_WIDTH (COORD_WIDTH),
                    .CNT_W       (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .prev_left  (c_left[k-1]),
                    .prev_right (c_right[k-1]),
                    .prev_valid (c_valid[k-1]),
                    .prev_peak  (c_peak[k-1]),
                    .left_out   (c_left[k]),
                    .right_out  (c_right[k]),
                    .valid_out  (c_valid[k]),
                    .peak_out   (c_peak[k])
                );
            end
        end
    endgenerate

    assign peak_ext = EXT_W'(c_peak[MAX_INTERVALS-1]);
    assign peak_sat = (peak_ext > EXT_W'(iot_pkg::PEAK_MAX)) ? iot_pkg::PEAK_MAX
                                                             : peak_ext[6:0];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        stored_next    = stored_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ctl            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (psel && penable && pwrite && pready && (paddr[2] == REG_COVER_THRESHOLD))
        begin
            thr_next = pwdata[15:0];
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (store)
                begin
                    ctl.shift   = 1'b1;
                    stored_next = stored_reg + CNT_W'(1);
                end
                if (set_end)
                begin
                    state_next = S_COUNT;
                    phase_next = '0;
                end
            end
            S_COUNT:
            begin
                ctl.rotate = 1'b1;
                phase_next = phase_reg + CNT_W'(1);
                if (phase_last)
                begin
                    state_next = S_PEAK;
                    phase_next = '0;
                end
            end
            S_PEAK:
            begin
                ctl.peak_en = 1'b1;
                phase_next  = phase_reg + CNT_W'(1);
                if (phase_last)
                begin
                    state_next = S_DONE;
                    phase_next = '0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.peak_cover    = peak_sat;
                    out_data_next.overlap_found = (stored_reg != '0)
                                                  && ({9'b0, peak_sat} >= thr_reg);
                    ctl.clear                   = 1'b1;
                    stored_next                 = '0;
                    state_next                  = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            phase_reg     <= '0;
            stored_reg    <= '0;
            thr_reg       <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stored_reg    <= stored_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_COVER_THRESHOLD) ? {16'b0, thr_reg} : 32'b0;

endmodule

`default_nettype wire

// ===== sim/iot_overlap_monitor.sv =====
`timescale 1ns / 1ps

module iot_overlap_monitor #(
    parameter int         MAX_INTERVALS = 64,
    parameter int         COORD_WIDTH   = 32,
    parameter logic [2:0] THRESH_ADDR   = 3'd0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  iot_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  iot_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 awaiting
);

    typedef logic [COORD_WIDTH-1:0] coord_t;

    coord_t             held_left[$];
    coord_t             held_right[$];
    iot_pkg::out_item_t verdicts[$];
    logic [15:0]        threshold;
    iot_pkg::out_item_t want;
    coord_t             lo;
    coord_t             hi;

    // closed-interval coverage is peaked at some stored left end
    function automatic iot_pkg::out_item_t peak_coverage();
        iot_pkg::out_item_t res;
        int                 peak;
        int                 cnt;
        peak = 0;
        foreach (held_left[j])
        begin
            cnt = 0;
            foreach (held_left[i])
            begin
                if (held_left[i] <= held_left[j] && held_left[j] <= held_right[i])
                    cnt++;
            end
            if (cnt > peak)
                peak = cnt;
        end
        if (peak > int'(iot_pkg::PEAK_MAX))
            peak = int'(iot_pkg::PEAK_MAX);
        res.overlap_found = (held_left.size() > 0) && (peak >= int'(threshold));
        res.peak_cover    = peak[6:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold = 16'd1;
            held_left.delete();
            held_right.delete();
            verdicts.delete();
            awaiting = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts.size() == 0)
                begin
                    $error("result transfer with nothing pending: overlap_found %0b peak_cover %0d",
                           out_data.overlap_found, out_data.peak_cover);
                    errors++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (out_data.overlap_found !== want.overlap_found)
                    begin
                        $error("overlap_found: expected %0b, got %0b",
                               want.overlap_found, out_data.overlap_found);
                        errors++;
                    end
                    if (out_data.peak_cover !== want.peak_cover)
                    begin
                        $error("peak_cover: expected %0d, got %0d",
                               want.peak_cover, out_data.peak_cover);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                lo = in_data.left_pos[COORD_WIDTH-1:0];
                hi = in_data.right_pos[COORD_WIDTH-1:0];
                if (!in_data.set_empty && hi >= lo && held_left.size() < MAX_INTERVALS)
                begin
                    held_left.push_back(lo);
                    held_right.push_back(hi);
                end
                if (in_data.last_interval || in_data.set_empty)
                begin
                    verdicts.push_back(peak_coverage());
                    held_left.delete();
                    held_right.delete();
                end
            end
            if (psel && penable && pwrite && pready && paddr == THRESH_ADDR)
                threshold = pwdata[15:0];
            awaiting = verdicts.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int         MAX_INTERVALS = 64;
    localparam int         COORD_WIDTH   = 32;
    localparam logic [2:0] THRESH_ADDR   = 3'd0;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES  = 2 * MAX_INTERVALS + 16;
    localparam int         PHASE_ITEMS   = 135;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    iot_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    iot_pkg::out_item_t out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int awaiting;
    int idle_run;
    bit no_gaps;
    int transfers_sent;
    int sets_sent;
    int settings_used;
    int levels[6] = '{0, 2, 65535, 64, 3, 1};

    interval_overlap_threshold_core #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    iot_overlap_monitor #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .COORD_WIDTH  (COORD_WIDTH),
        .THRESH_ADDR  (THRESH_ADDR)
    ) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .errors   (errors),
        .awaiting (awaiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !no_gaps && ($urandom_range(99) < 24);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("FAIL interval_overlap_threshold_core");
                $finish;
            end
        end
    end

    task automatic send(input logic [31:0] l, input logic [31:0] r,
                        input logic last, input logic empty);
        iot_pkg::in_item_t item;
        while (!no_gaps && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.left_pos      = l;
        item.right_pos     = r;
        item.last_interval = last;
        item.set_empty     = empty;
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        transfers_sent++;
        if (last || empty)
            sets_sent++;
    endtask

    task automatic set_threshold(input logic [15:0] level);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESH_ADDR;
        pwdata  <= {16'($urandom_range(65535)), level};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_interval(input logic [63:0] base, input logic last);
        logic [63:0] l;
        logic [63:0] r;
        logic [31:0] a;
        logic [31:0] b;
        int          pick;
        pick = $urandom_range(99);
        a    = $urandom;
        b    = $urandom;
        if (pick < 60)
        begin
            l = base + 64'($urandom_range(63));
            r = l + 64'($urandom_range(40));
            if (l > 64'hFFFF_FFFF)
                l = 64'hFFFF_FFFF;
            if (r > 64'hFFFF_FFFF)
                r = 64'hFFFF_FFFF;
        end
        else if (pick < 85)
        begin
            l = 64'((a < b) ? a : b);
            r = 64'((a < b) ? b : a);
        end
        else if (pick < 93)
        begin
            // reversed interval
            if (a == b)
                b = a ^ 32'd1;
            l = 64'((a < b) ? b : a);
            r = 64'((a < b) ? a : b);
        end
        else
        begin
            l = 64'(a);
            r = 64'(a);
        end
        send(l[31:0], r[31:0], last, 1'b0);
    endtask

    task automatic send_set(input int count);
        logic [63:0] base;
        int          k;
        int          ending;
        int          region;
        region = $urandom_range(2);
        if (region == 0)
            base = 64'($urandom_range(200));
        else if (region == 1)
            base = 64'hFFFF_FFFF - 64'($urandom_range(80));
        else
            base = 64'($urandom);
        ending = $urandom_range(99);
        if (count == 0)
        begin
            send($urandom, $urandom, $urandom_range(1) == 1, 1'b1);
            return;
        end
        for (k = 0; k < count; k++)
            send_interval(base, (k == count - 1) && ending >= 12);
        // set closed by an empty marker on top of stored intervals
        if (ending < 12)
            send($urandom, $urandom, $urandom_range(1) == 1, 1'b1);
    endtask

    task automatic send_crowd(input int count);
        logic [31:0] mid;
        int          k;
        mid = 32'h8000_0000;
        for (k = 0; k < count; k++)
            send(mid - $urandom_range(1000), mid + $urandom_range(1000),
                 k == count - 1, 1'b0);
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int roll;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        no_gaps        = 1'b0;
        idle_run       = 0;
        transfers_sent = 0;
        sets_sent      = 0;
        settings_used  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send(32'd5, 32'd10, 1'b0, 1'b0);
        send(32'd10, 32'd20, 1'b1, 1'b0);
        send(32'hDEAD_BEEF, 32'h0123_4567, 1'b1, 1'b1);
        send(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1);
        send(32'd20, 32'd10, 1'b1, 1'b0);
        send(32'd1, 32'd1, 1'b0, 1'b0);
        send(32'd3, 32'd2, 1'b1, 1'b0);
        send(32'd7, 32'd9, 1'b0, 1'b0);
        send(32'd0, 32'd0, 1'b0, 1'b1);
        drain();
        set_threshold(16'd0);
        send(32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b0);
        send(32'd0, 32'd0, 1'b1, 1'b1);
        send(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0);
        drain();
        set_threshold(16'hFFFF);
        send(32'd0, 32'd0, 1'b1, 1'b0);
        send(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send(32'd0, 32'd0, 1'b1, 1'b0);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                set_threshold(16'($urandom_range(5, 1)));
            else
                set_threshold(16'(levels[phase]));
            no_gaps     = (phase == 2);
            phase_start = transfers_sent;
            if (phase == 0 || levels[phase] == 64)
                send_crowd(MAX_INTERVALS + 2);
            while (transfers_sent - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    send_set(0);
                else if (roll < 11)
                    send_set($urandom_range(70, 60));
                else
                    send_set($urandom_range(8, 1));
            end
            drain();
            no_gaps = 1'b0;
        end

        $display("sent %0d transfers closing %0d sets over %0d threshold settings",
                 transfers_sent, sets_sent, settings_used);
        if (errors == 0)
            $display("PASS interval_overlap_threshold_core");
        else
            $display("FAIL interval_overlap_threshold_core");
        $finish;
    end

endmodule
